// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_HOLDS(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// condition that must hold on the cycle after reset is seen
`define ASSERT_AFTER_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("assertion failed: after reset");

`endif

// ===== rtl/core/dolq_pkg.sv =====
// shared types and constants of the drop-oldest line queue
package dolq_pkg;

  // fixed field widths
  localparam int BYTE_LANES  = 8;
  localparam int WORD_W      = 64;
  localparam int BYTES_W     = 4;
  localparam int COUNT_W     = 32;
  // command length field covers the largest line limit
  localparam int LEN_FIELD_W = 9;
  // depth of the command queue between front and back
  localparam int CMD_DEPTH   = 2;

  // item kinds
  localparam logic ACT_LINE = 1'b0;
  localparam logic ACT_POLL = 1'b1;

  typedef struct packed {
    logic               action;
    logic [WORD_W-1:0]  line_word;
    logic [BYTES_W-1:0] word_bytes;
    logic               last_word;
    logic               link_subscribed;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  out_word;
    logic [BYTES_W-1:0] out_bytes;
    logic               end_of_line;
    logic               end_of_poll;
    logic [COUNT_W-1:0] drops_total;
    logic [COUNT_W-1:0] lines_sent_total;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_COMMIT,
    CMD_FLUSH,
    CMD_POLL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [LEN_FIELD_W-1:0] len;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_SEND
  } back_state_t;

endpackage

// ===== rtl/core/dolq_cmd_fifo.sv =====
// small command queue between the front and the back
module dolq_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dolq_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output dolq_pkg::cmd_t dout,
  output logic          empty
);

  localparam int PTR_W = $clog2(dolq_pkg::CMD_DEPTH);
  localparam int CNT_W = $clog2(dolq_pkg::CMD_DEPTH + 1);

  dolq_pkg::cmd_t   entries [dolq_pkg::CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  // status
  assign full    = (count == CNT_W'(dolq_pkg::CMD_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

// ===== rtl/core/dolq_store.sv =====
// line storage: one byte-wide memory per lane, per-lane write, shared read
module dolq_store #(
  parameter int SLOTS = 9,
  parameter int ROW_W = 4
) (
  input  logic                                                   clk,
  input  logic [dolq_pkg::BYTE_LANES-1:0]                        wr_en,
  input  logic [dolq_pkg::BYTE_LANES-1:0][$clog2(SLOTS)+ROW_W-1:0] wr_addr,
  input  logic [dolq_pkg::WORD_W-1:0]                            wr_data,
  input  logic                                                   rd_en,
  input  logic [$clog2(SLOTS)+ROW_W-1:0]                         rd_addr,
  output logic [dolq_pkg::WORD_W-1:0]                            rd_data
);

  localparam int DEPTH = SLOTS << ROW_W;

  for (genvar j = 0; j < dolq_pkg::BYTE_LANES; j++) begin : g_lane
    logic [7:0] mem [DEPTH];

    // lane write and registered read
    always_ff @(posedge clk) begin
      if (wr_en[j]) begin
        mem[wr_addr[j]] <= wr_data[8*j +: 8];
      end
      if (rd_en) begin
        rd_data[8*j +: 8] <= mem[rd_addr];
      end
    end
  end

endmodule

// ===== rtl/core/dolq_front.sv =====
// front: takes items, packs line bytes into the staging slot, issues commands
module dolq_front #(
  parameter int QUEUE_LINES = 8,
  parameter int LINE_MAX    = 120
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic                                   cfg_wr_data,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  dolq_pkg::in_item_t                     item,
  input  logic                                   cmd_full,
  input  logic                                   poll_done,
  output logic                                   cmd_push,
  output dolq_pkg::cmd_t                         cmd,
  output logic [dolq_pkg::BYTE_LANES-1:0]        st_wr_en,
  output logic [dolq_pkg::BYTE_LANES-1:0][$clog2(QUEUE_LINES+1)+$clog2((LINE_MAX+7)/8)-1:0]
                                                 st_wr_addr,
  output logic [dolq_pkg::WORD_W-1:0]            st_wr_data
);

  localparam int SLOTS      = QUEUE_LINES + 1;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int LINE_WORDS = (LINE_MAX + 7) / 8;
  localparam int ROW_W      = $clog2(LINE_WORDS);
  localparam int LEN_W      = $clog2(LINE_MAX + 1);
  localparam int POS_W      = LEN_W + 1;
  localparam int UP_W       = LEN_W - 2;

  logic              link_en;
  logic              subscribed;
  logic              poll_open;
  logic [LEN_W-1:0]  stage_len;
  logic [SLOT_W-1:0] wr_slot;

  logic                             accept;
  logic                             is_line;
  logic [dolq_pkg::BYTES_W-1:0]     nb;
  logic [POS_W-1:0]                 sum;
  logic                             oversize;
  logic [LEN_W-1:0]                 len_new;
  logic                             commit;
  logic [2:0]                       offset;

  // handshake: hold items while a poll drains or the queue is full
  assign item_stall = cmd_full || poll_open;
  assign accept     = item_valid && !item_stall;
  assign is_line    = (item.action == dolq_pkg::ACT_LINE);

  // byte count and staging length update
  assign nb       = (item.word_bytes > dolq_pkg::BYTES_W'(8)) ?
                    dolq_pkg::BYTES_W'(8) : item.word_bytes;
  assign sum      = POS_W'(stage_len) + POS_W'(nb);
  assign oversize = (sum >= POS_W'(LINE_MAX));
  assign len_new  = oversize ? LEN_W'(LINE_MAX) : LEN_W'(sum);
  assign commit   = accept && is_line && item.last_word && link_en && subscribed &&
                    !oversize;
  assign offset   = stage_len[2:0];

  // byte lanes: each lane takes the input byte that lands on it
  always_comb begin
    for (int j = 0; j < dolq_pkg::BYTE_LANES; j++) begin
      logic [2:0]       idx;
      logic             carry;
      logic [UP_W-1:0]  up;
      logic [POS_W-1:0] pos;
      idx   = 3'(j) - offset;
      carry = (3'(j) < offset);
      up    = UP_W'(stage_len[LEN_W-1:3]) + UP_W'(carry);
      pos   = {up, 3'(j)};
      st_wr_en[j]          = accept && is_line && (dolq_pkg::BYTES_W'(idx) < nb) &&
                             (pos < POS_W'(LINE_MAX));
      st_wr_addr[j]        = {wr_slot, ROW_W'(up)};
      st_wr_data[8*j +: 8] = item.line_word[8*idx +: 8];
    end
  end

  // command to the back
  always_comb begin
    cmd_push = 1'b0;
    cmd.kind = dolq_pkg::CMD_COMMIT;
    cmd.len  = dolq_pkg::LEN_FIELD_W'(len_new);
    if (commit) begin
      cmd_push = 1'b1;
    end else if (accept && !is_line && link_en) begin
      cmd_push = 1'b1;
      cmd.kind = item.link_subscribed ? dolq_pkg::CMD_POLL : dolq_pkg::CMD_FLUSH;
    end
  end

  // front state
  always_ff @(posedge clk) begin
    if (rst) begin
      link_en    <= 1'b0;
      subscribed <= 1'b0;
      poll_open  <= 1'b0;
      stage_len  <= '0;
      wr_slot    <= '0;
    end else begin
      if (cfg_wr_en) begin
        link_en <= cfg_wr_data;
      end
      if (accept && is_line) begin
        stage_len <= item.last_word ? '0 : len_new;
      end
      if (commit) begin
        wr_slot <= (wr_slot == SLOT_W'(SLOTS - 1)) ? '0 : wr_slot + SLOT_W'(1);
      end
      if (accept && !is_line && link_en) begin
        subscribed <= item.link_subscribed;
      end
      if (poll_done) begin
        poll_open <= 1'b0;
      end else if (accept && !is_line && link_en && item.link_subscribed) begin
        poll_open <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/dolq_back.sv =====
// back: ring bookkeeping, drop and send counters, word-by-word burst output
module dolq_back #(
  parameter int QUEUE_LINES = 8,
  parameter int LINE_MAX    = 120,
  parameter int BURST_LINES = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_avail,
  input  dolq_pkg::cmd_t                    cmd,
  output logic                              cmd_pop,
  output logic                              poll_done,
  output logic                              rd_en,
  output logic [$clog2(QUEUE_LINES+1)+$clog2((LINE_MAX+7)/8)-1:0] rd_addr,
  input  logic [dolq_pkg::WORD_W-1:0]       rd_data,
  output logic                              result_valid,
  input  logic                              result_stall,
  output dolq_pkg::out_item_t               result
);

  localparam int SLOTS      = QUEUE_LINES + 1;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int LINE_WORDS = (LINE_MAX + 7) / 8;
  localparam int ROW_W      = $clog2(LINE_WORDS);
  localparam int LEN_W      = $clog2(LINE_MAX + 1);
  localparam int POS_W      = LEN_W + 1;
  localparam int FILL_W     = $clog2(QUEUE_LINES + 1);
  localparam int BURST_W    = $clog2(BURST_LINES + 1);

  dolq_pkg::back_state_t state;
  dolq_pkg::back_state_t state_next;

  logic [SLOT_W-1:0]            head;
  logic [SLOT_W-1:0]            tail;
  logic [FILL_W-1:0]            fill;
  logic [dolq_pkg::COUNT_W-1:0] drops;
  logic [dolq_pkg::COUNT_W-1:0] sent;
  logic [LEN_W-1:0]             slot_len [SLOTS];
  logic [BURST_W-1:0]           lines;
  logic [ROW_W-1:0]             word_idx;
  logic                         out_valid;
  dolq_pkg::out_item_t          out_item;

  logic [LEN_W-1:0]             cur_len;
  logic [POS_W-1:0]             rem;
  logic                         last_word;
  logic                         last_line;
  logic [dolq_pkg::BYTES_W-1:0] nbytes;
  logic [dolq_pkg::WORD_W-1:0]  keep_mask;
  logic                         load;
  logic                         start_poll;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  // current word of the line being sent
  assign cur_len   = slot_len[head];
  assign rem       = POS_W'(cur_len) - (POS_W'(word_idx) << 3);
  assign last_word = (rem <= POS_W'(8));
  assign nbytes    = last_word ? dolq_pkg::BYTES_W'(rem) : dolq_pkg::BYTES_W'(8);
  assign last_line = (lines == BURST_W'(BURST_LINES - 1)) || (fill == FILL_W'(1));
  assign load      = (state == dolq_pkg::BK_SEND) && (!out_valid || !result_stall);
  assign cmd_pop   = (state == dolq_pkg::BK_IDLE) && cmd_avail;
  assign start_poll = cmd_pop && (cmd.kind == dolq_pkg::CMD_POLL) && (fill != '0);

  // byte mask for a partial word
  always_comb begin
    for (int j = 0; j < dolq_pkg::BYTE_LANES; j++) begin
      keep_mask[8*j +: 8] = (dolq_pkg::BYTES_W'(j) < nbytes) ? 8'hFF : 8'h00;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dolq_pkg::BK_IDLE: begin
        if (start_poll) begin
          state_next = dolq_pkg::BK_SEND;
        end
      end
      dolq_pkg::BK_SEND: begin
        if (load && last_word && last_line) begin
          state_next = dolq_pkg::BK_IDLE;
        end
      end
      default: state_next = dolq_pkg::BK_IDLE;
    endcase
  end

  // read port and poll completion
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = {head, word_idx};
    poll_done = 1'b0;
    unique case (state)
      dolq_pkg::BK_IDLE: begin
        rd_addr   = {head, ROW_W'(0)};
        rd_en     = start_poll;
        poll_done = cmd_pop && (cmd.kind == dolq_pkg::CMD_POLL) && (fill == '0);
      end
      dolq_pkg::BK_SEND: begin
        if (load) begin
          if (last_word) begin
            poll_done = last_line;
            rd_en     = !last_line;
            rd_addr   = {next_slot(head), ROW_W'(0)};
          end else begin
            rd_en   = 1'b1;
            rd_addr = {head, word_idx + ROW_W'(1)};
          end
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // ring pointers, counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dolq_pkg::BK_IDLE;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      drops     <= '0;
      sent      <= '0;
      lines     <= '0;
      word_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_pop) begin
        case (cmd.kind)
          dolq_pkg::CMD_COMMIT: begin
            tail <= next_slot(tail);
            if (fill == FILL_W'(QUEUE_LINES)) begin
              head  <= next_slot(head);
              drops <= drops + dolq_pkg::COUNT_W'(1);
            end else begin
              fill <= fill + FILL_W'(1);
            end
          end
          dolq_pkg::CMD_FLUSH: begin
            head <= tail;
            fill <= '0;
          end
          dolq_pkg::CMD_POLL: begin
            lines    <= '0;
            word_idx <= '0;
          end
          default: begin
            lines <= lines;
          end
        endcase
      end
      if (load) begin
        if (last_word) begin
          sent     <= sent + dolq_pkg::COUNT_W'(1);
          head     <= next_slot(head);
          fill     <= fill - FILL_W'(1);
          lines    <= lines + BURST_W'(1);
          word_idx <= '0;
        end else begin
          word_idx <= word_idx + ROW_W'(1);
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!result_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // line lengths per slot
  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.kind == dolq_pkg::CMD_COMMIT)) begin
      slot_len[tail] <= LEN_W'(cmd.len);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_item.out_word         <= rd_data & keep_mask;
      out_item.out_bytes        <= nbytes;
      out_item.end_of_line      <= last_word;
      out_item.end_of_poll      <= last_word && last_line;
      out_item.drops_total      <= drops;
      out_item.lines_sent_total <= sent + dolq_pkg::COUNT_W'(1);
    end
  end

  assign result_valid = out_valid;
  assign result       = out_item;

endmodule

// ===== rtl/core/drop_oldest_line_queue_core.sv =====
// drop-oldest line queue top: front, command queue, line store, back
// line words: one per cycle while item_stall is low; the word is stored when accepted
// polls: the first word passes the command queue, the store's registered read port and
//   the output register, then one per cycle unless result_stall; items wait till it drains
// reset (synchronous, active high) empties the ring, clears counters and disables the link
module drop_oldest_line_queue_core #(
  parameter int QUEUE_LINES = 8,
  parameter int LINE_MAX    = 120,
  parameter int BURST_LINES = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                item_valid,
  output logic                item_stall,
  input  dolq_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output dolq_pkg::out_item_t result
);

  localparam int SLOTS      = QUEUE_LINES + 1;
  localparam int LINE_WORDS = (LINE_MAX + 7) / 8;
  localparam int ROW_W      = $clog2(LINE_WORDS);
  localparam int ADDR_W     = $clog2(SLOTS) + ROW_W;

  logic                                         cmd_push;
  logic                                         cmd_full;
  logic                                         cmd_empty;
  logic                                         cmd_pop;
  logic                                         poll_done;
  dolq_pkg::cmd_t                               cmd_in;
  dolq_pkg::cmd_t                               cmd_out;
  logic [dolq_pkg::BYTE_LANES-1:0]              st_wr_en;
  logic [dolq_pkg::BYTE_LANES-1:0][ADDR_W-1:0]  st_wr_addr;
  logic [dolq_pkg::WORD_W-1:0]                  st_wr_data;
  logic                                         rd_en;
  logic [ADDR_W-1:0]                            rd_addr;
  logic [dolq_pkg::WORD_W-1:0]                  rd_data;

  // item intake and staging
  dolq_front #(
    .QUEUE_LINES (QUEUE_LINES),
    .LINE_MAX    (LINE_MAX)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .cmd_full    (cmd_full),
    .poll_done   (poll_done),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in),
    .st_wr_en    (st_wr_en),
    .st_wr_addr  (st_wr_addr),
    .st_wr_data  (st_wr_data)
  );

  // commands from front to back
  dolq_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  // ring of line slots plus one staging slot
  dolq_store #(
    .SLOTS (SLOTS),
    .ROW_W (ROW_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ring control and output
  dolq_back #(
    .QUEUE_LINES (QUEUE_LINES),
    .LINE_MAX    (LINE_MAX),
    .BURST_LINES (BURST_LINES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_avail    (!cmd_empty),
    .cmd          (cmd_out),
    .cmd_pop      (cmd_pop),
    .poll_done    (poll_done),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== rtl/core/dolq_checker.sv =====
// port-level checker for the drop-oldest line queue, bound to the top level
`include "assert_macros.svh"

module dolq_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_stall,
  input logic                result_valid,
  input logic                result_stall,
  input dolq_pkg::out_item_t result
);

  // no result right after reset
  `ASSERT_AFTER_RESET(a_no_result_after_reset, clk, rst, !result_valid)

  // a stalled result stays in place
  `ASSERT_NEXT(a_result_held, clk, rst, result_valid && result_stall, result_valid && $stable(result))

  // input is held off while a poll is still draining
  `ASSERT_HOLDS(a_stall_mid_poll, clk, rst, result_valid && !result.end_of_poll, item_stall)

  // only the last word of a line may be partial
  `ASSERT_HOLDS(a_full_inner_word, clk, rst, result_valid && !result.end_of_line, result.out_bytes == 4'd8)

endmodule

bind drop_oldest_line_queue_core dolq_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== bench/tb_drop_oldest_line_queue_core.sv =====
// testbench for the drop-oldest line queue: directed table, random lines and polls, predictor check
module tb_drop_oldest_line_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_LINES = 8;
  localparam int LINE_MAX    = 120;
  localparam int BURST_LINES = 3;
  localparam int LINE_WORDS  = (LINE_MAX + 7) / 8;
  // directed and random items together
  localparam int TOTAL_ITEMS = 280;

  // directed table row layout
  typedef enum logic {ROW_ITEM, ROW_LINK} row_kind_t;
  typedef enum logic [1:0] {WANT_MODEL, WANT_NONE, WANT_ONE} want_t;

  typedef struct packed {
    row_kind_t           kind;
    logic                link;
    logic [4:0]          reps;
    want_t               want;
    dolq_pkg::in_item_t  it;
    dolq_pkg::out_item_t one;
  } plan_row_t;

  localparam dolq_pkg::out_item_t NO_RESULT = '0;
  localparam int PLAN_ROWS = 30;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // poll and line while the link is still off
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_POLL, 64'h0, 4'd0, 1'b0, 1'b1}, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_LINE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b0}, NO_RESULT},
    '{ROW_LINK, 1'b1, 5'd0, WANT_NONE, '0, NO_RESULT},
    // subscribe with nothing queued
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_POLL, 64'h0, 4'd0, 1'b0, 1'b1}, NO_RESULT},
    // fill every slot, byte count extremes
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_LINE, 64'h0123_4567_89AB_CDEF, 4'd8, 1'b1, 1'b0}, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_LINE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1, 1'b0}, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_LINE, 64'h0, 4'd8, 1'b1, 1'b0}, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_LINE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 1'b0}, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_LINE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, 1'b1}, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_LINE, 64'hA5A5_5A5A_C3C3_3C3C, 4'd3, 1'b1, 1'b0}, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd2, WANT_NONE,
      '{dolq_pkg::ACT_LINE, 64'h8899_AABB_CCDD_EEFF, 4'd8, 1'b0, 1'b0}, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_LINE, 64'h1122_3344_5566_7788, 4'd7, 1'b1, 1'b0}, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_LINE, 64'hFEDC_BA98_7654_3210, 4'd4, 1'b1, 1'b0}, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_LINE, 64'h0F1E_2D3C_4B5A_6978, 4'd5, 1'b1, 1'b0}, NO_RESULT},
    // ring full: oldest line dropped
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_LINE, 64'h55AA_55AA_55AA_55AA, 4'd6, 1'b1, 1'b0}, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_MODEL,
      '{dolq_pkg::ACT_POLL, 64'h0, 4'd0, 1'b0, 1'b1}, NO_RESULT},
    // unsubscribed poll flushes, then nothing to send
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_POLL, 64'h0, 4'd0, 1'b0, 1'b0}, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_POLL, 64'h0, 4'd0, 1'b0, 1'b1}, NO_RESULT},
    // empty line comes out as one zero word
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_LINE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 1'b0}, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_ONE,
      '{dolq_pkg::ACT_POLL, 64'h0, 4'd0, 1'b0, 1'b1},
      '{64'h0, 4'd0, 1'b1, 1'b1, 32'd1, 32'd4}},
    // exactly the limit: dropped whole, not counted
    '{ROW_ITEM, 1'b0, 5'd15, WANT_NONE,
      '{dolq_pkg::ACT_LINE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b0}, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_POLL, 64'h0, 4'd0, 1'b0, 1'b1}, NO_RESULT},
    // one byte under the limit: queued, fifteen words
    '{ROW_ITEM, 1'b0, 5'd14, WANT_NONE,
      '{dolq_pkg::ACT_LINE, 64'h7766_5544_3322_1100, 4'd8, 1'b0, 1'b0}, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_LINE, 64'h00FF_00FF_00FF_00FF, 4'd7, 1'b1, 1'b0}, NO_RESULT},
    // link off: poll changes nothing, line is not queued
    '{ROW_LINK, 1'b0, 5'd0, WANT_NONE, '0, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_POLL, 64'h0, 4'd0, 1'b0, 1'b0}, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_LINE, 64'h0123_4567_89AB_CDEF, 4'd3, 1'b1, 1'b0}, NO_RESULT},
    '{ROW_LINK, 1'b1, 5'd0, WANT_NONE, '0, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_MODEL,
      '{dolq_pkg::ACT_POLL, 64'h0, 4'd0, 1'b0, 1'b1}, NO_RESULT},
    '{ROW_ITEM, 1'b0, 5'd1, WANT_NONE,
      '{dolq_pkg::ACT_POLL, 64'h0, 4'd0, 1'b0, 1'b0}, NO_RESULT}
  };

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic                cfg_wr_data;
  logic                item_valid;
  logic                item_stall;
  dolq_pkg::in_item_t  item;
  logic                result_valid;
  logic                result_stall;
  dolq_pkg::out_item_t result;

  // line queue predictor state
  bit [63:0]   ring_words [QUEUE_LINES][LINE_WORDS];
  int unsigned ring_len [QUEUE_LINES];
  bit [63:0]   stage_words [LINE_WORDS];
  int unsigned stage_len;
  bit          stage_big;
  int unsigned wr_slot;
  int unsigned rd_slot;
  int unsigned fill;
  bit          sub_seen;
  bit          link_on;
  bit [31:0]   drops;
  bit [31:0]   sent;

  dolq_pkg::out_item_t step_words [$];
  dolq_pkg::out_item_t pending_words [$];
  int        mismatches;
  int        items_sent;
  bit        sender_quiet;

  drop_oldest_line_queue_core #(
    .QUEUE_LINES(QUEUE_LINES),
    .LINE_MAX   (LINE_MAX),
    .BURST_LINES(BURST_LINES)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("tb_drop_oldest_line_queue_core: FAIL");
    $finish;
  end

  // mostly short pauses, a few long ones
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // advance the line queue by one item, results land in step_words
  task automatic predict_line_queue(input dolq_pkg::in_item_t it);
    int unsigned nb;
    int unsigned pos;
    int unsigned nw;
    int unsigned rem;
    int unsigned lines;
    bit [63:0]   w;
    dolq_pkg::out_item_t o;
    step_words.delete();
    lines = 0;
    if (it.action == dolq_pkg::ACT_LINE) begin
      nb = (it.word_bytes > 4'd8) ? 8 : it.word_bytes;
      for (int i = 0; i < nb; i++) begin
        pos = stage_len + i;
        if (pos < LINE_MAX) stage_words[pos / 8][(pos % 8) * 8 +: 8] = it.line_word[i * 8 +: 8];
      end
      if (stage_len + nb >= LINE_MAX) begin
        stage_big = 1'b1;
        stage_len = LINE_MAX;
      end else begin
        stage_len += nb;
      end
      if (it.last_word) begin
        if (link_on && sub_seen && !stage_big) begin
          // full ring: oldest line goes
          if (fill >= QUEUE_LINES) begin
            rd_slot = (rd_slot + 1) % QUEUE_LINES;
            fill = QUEUE_LINES - 1;
            drops++;
          end
          for (int k = 0; k < LINE_WORDS; k++) ring_words[wr_slot][k] = stage_words[k];
          ring_len[wr_slot] = stage_len;
          wr_slot = (wr_slot + 1) % QUEUE_LINES;
          fill++;
        end
        stage_len = 0;
        stage_big = 1'b0;
      end
    end else if (link_on) begin
      sub_seen = it.link_subscribed;
      if (!sub_seen) begin
        rd_slot = wr_slot;
        fill = 0;
      end
      // burst of the oldest lines
      while (sub_seen && fill > 0 && lines < BURST_LINES) begin
        nw = (ring_len[rd_slot] + 7) / 8;
        if (nw == 0) nw = 1;
        sent++;
        for (int k = 0; k < nw; k++) begin
          rem = (ring_len[rd_slot] > k * 8) ? ring_len[rd_slot] - k * 8 : 0;
          if (rem > 8) rem = 8;
          w = ring_words[rd_slot][k];
          if (rem < 8) w &= (64'd1 << (8 * rem)) - 64'd1;
          o.out_word = w;
          o.out_bytes = rem[3:0];
          o.end_of_line = (k + 1 == nw);
          o.end_of_poll = 1'b0;
          o.drops_total = drops;
          o.lines_sent_total = sent;
          step_words.push_back(o);
        end
        rd_slot = (rd_slot + 1) % QUEUE_LINES;
        fill--;
        lines++;
      end
      if (step_words.size() > 0) begin
        o = step_words.pop_back();
        o.end_of_poll = 1'b1;
        step_words.push_back(o);
      end
    end
  endtask

  // offer one item, return at the edge that takes it
  task automatic send_item(input dolq_pkg::in_item_t it, input want_t want,
                           input dolq_pkg::out_item_t one);
    int pause;
    pause = sender_quiet ? 0 : pick_pause();
    if (pause > 0) begin
      item_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(negedge clk);
    while (item_stall !== 1'b0) @(negedge clk);
    items_sent++;
    predict_line_queue(it);
    case (want)
      WANT_MODEL: foreach (step_words[i]) pending_words.push_back(step_words[i]);
      WANT_ONE:   pending_words.push_back(one);
      default:    ;
    endcase
    @(posedge clk);
  endtask

  // block idle: all results in, then room for trailing work
  task automatic settle();
    item_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_link(input bit on);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= on;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    link_on = on;
  endtask

  task automatic send_random(input dolq_pkg::in_item_t it);
    send_item(it, WANT_MODEL, NO_RESULT);
  endtask

  function automatic void match_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  // result side stall pattern
  initial begin
    int hold;
    result_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = pick_pause();
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6))
        @(posedge clk);
    end
  end

  // compare each taken result word with the oldest expectation
  initial begin
    dolq_pkg::out_item_t want;
    forever begin
      @(negedge clk);
      if (rst === 1'b0 && result_valid === 1'b1 && result_stall === 1'b0) begin
        if (pending_words.size() == 0) begin
          $error("unexpected result word %h", result.out_word);
          mismatches++;
        end else begin
          want = pending_words.pop_front();
          match_field("out_word", want.out_word, result.out_word);
          match_field("out_bytes", 64'(want.out_bytes), 64'(result.out_bytes));
          match_field("end_of_line", 64'(want.end_of_line), 64'(result.end_of_line));
          match_field("end_of_poll", 64'(want.end_of_poll), 64'(result.end_of_poll));
          match_field("drops_total", 64'(want.drops_total), 64'(result.drops_total));
          match_field("lines_sent_total", 64'(want.lines_sent_total),
                      64'(result.lines_sent_total));
        end
      end
    end
  end

  // stimulus
  initial begin
    dolq_pkg::in_item_t word;
    int       r;
    int       nwords;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 1'b0;
    item_valid <= 1'b0;
    item <= '0;
    mismatches = 0;
    items_sent = 0;
    sender_quiet = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int row = 0; row < PLAN_ROWS; row++) begin
      if (PLAN[row].kind == ROW_LINK) begin
        set_link(PLAN[row].link);
      end else begin
        for (int k = 0; k < PLAN[row].reps; k++) begin
          word = PLAN[row].it;
          if (k != PLAN[row].reps - 1) word.last_word = 1'b0;
          send_item(word, PLAN[row].want, PLAN[row].one);
        end
      end
    end

    // random lines and polls
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 29) == 0) sender_quiet = ~sender_quiet;
      if ($urandom_range(0, 9) == 0) set_link($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        word = '{dolq_pkg::ACT_POLL, rand_word(), 4'($urandom), 1'($urandom),
                 ($urandom_range(0, 6) != 0)};
        send_random(word);
      end else begin
        r = $urandom_range(0, 99);
        nwords = (r < 85) ? $urandom_range(1, 4) :
                 (r < 95) ? $urandom_range(5, 14) : $urandom_range(15, 17);
        for (int k = 0; k < nwords; k++) begin
          // stray poll in the middle of a line
          if ($urandom_range(0, 19) == 0) begin
            word = '{dolq_pkg::ACT_POLL, rand_word(), 4'($urandom), 1'($urandom),
                     ($urandom_range(0, 3) != 0)};
            send_random(word);
          end
          word.action = dolq_pkg::ACT_LINE;
          word.line_word = rand_word();
          word.word_bytes = ($urandom_range(0, 4) != 0) ? 4'd8 : 4'($urandom_range(0, 15));
          word.last_word = (k == nwords - 1);
          word.link_subscribed = 1'($urandom);
          send_random(word);
        end
      end
    end

    settle();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_drop_oldest_line_queue_core: PASS");
    end else begin
      $display("tb_drop_oldest_line_queue_core: FAIL");
    end
    $finish;
  end

endmodule
